// ----- hdl/plirs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plirs_pkg
// Shared types and constants for the positional list block.
// ----------------------------------------------------------------------------
package plirs_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    localparam int OP_W  = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam int LEN_W = 5;

    localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // broadcast to every cell of the row
    typedef struct packed {
        logic             acc;
        logic             ins;
        logic             rem;
        logic             srch;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- hdl/plirs_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plirs_cell
// One list slot: holds an element, shifts from either neighbor, matches.
// ----------------------------------------------------------------------------
module plirs_cell
    import plirs_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF,
    parameter int IDX    = 0
) (
    input  wire                           i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire [$clog2(DEPTH+1)-1:0]     i_count,
    input  wire [DATA_W-1:0]              i_value,
    input  wire [DATA_W-1:0]              i_left,
    input  wire [DATA_W-1:0]              i_right,
    output logic [DATA_W-1:0]             o_data,
    output logic [DATA_W-1:0]             o_sel_data,
    output logic                          o_hit
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] IDX_V = CMP_W'(IDX);
    localparam logic [CMP_W-1:0] IDX_P = CMP_W'(IDX + 1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              r_hit;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_cnt;

    assign w_pos = CMP_W'(i_ctl.pos);
    assign w_cnt = CMP_W'(i_count);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (IDX_V > w_pos) begin
                n_data = i_left;
            end else if (IDX_V == w_pos) begin
                n_data = i_value;
            end
        end else if (i_ctl.rem) begin
            if (IDX_P >= w_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.acc) begin
            r_hit <= i_ctl.srch && (r_data == i_value) && (IDX_V < w_cnt);
        end
    end

    assign o_data     = r_data;
    assign o_sel_data = (i_ctl.rem && IDX_P == w_pos) ? r_data : '0;
    assign o_hit      = r_hit;

endmodule
`default_nettype wire

// ----- hdl/positional_list_insert_remove_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_insert_remove_search
// Ordered list in a row of cells with insert, remove and search.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter on s_axis (tuser = operation, tdata = position and
//   value); one result word per command leaves on m_axis (tuser = ok,
//   tdata = removed value, found position, length). Capacity is written on
//   the cfg channel; the user writes it only while no command is in flight,
//   which the block does not enforce. Each cell holds one slot; an insert or
//   remove shifts the slots from the given position onward at once, each
//   from its neighbor, and a search compares all slots in parallel in the
//   accept cycle. The match vector is registered, resolved to the first
//   position and registered into the output stage once that stage is free.
//   Throughput: one command per cycle while m_axis_tready is high.
//   Reset: list empty, capacity 16, no result pending; slot contents are
//   not cleared and are never read before being written.
//   Receiver stall: the match stage and the output register hold one result
//   each; once both are full, s_axis_tready drops until a word is taken.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_search
    import plirs_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // position[4:0], value[36:5], zero
    input  wire  [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // removed_value[31:0], found[36:32],
                                        // length[41:37], zero
    output logic [0:0]  m_axis_tuser,   // ok[0]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [4:0]  i_cfg_data      // capacity
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic [OP_W-1:0]   w_op;
    logic [POS_W-1:0]  w_pos;
    logic [DATA_W-1:0] w_val;
    logic              w_acc;
    logic              w_ins_ok;
    logic              w_rem_ok;
    logic [CMP_W-1:0]  w_pos_e;
    logic [CMP_W-1:0]  w_cnt_e;
    t_cell_ctl         w_ctl;

    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DATA_W-1:0] w_sel  [DEPTH];
    logic [DEPTH-1:0]  w_hit;
    logic [DATA_W-1:0] w_rdata;

    logic              r_s1_valid;
    logic              r_s1_ok;
    logic              r_s1_srch;
    logic [DATA_W-1:0] r_s1_rdata;
    logic [CNT_W-1:0]  r_s1_len;
    logic              w_s1_go;

    logic [DEPTH-1:0]  w_first;
    logic [IDX_W-1:0]  w_idx;
    logic              w_any;
    logic [CNT_W-1:0]  w_found;

    logic              r_ov;
    logic              r_o_ok;
    logic [VAL_W-1:0]  r_o_rdata;
    logic [LEN_W-1:0]  r_o_found;
    logic [LEN_W-1:0]  r_o_len;

    assign w_op    = s_axis_tuser;
    assign w_pos   = s_axis_tdata[4:0];
    assign w_val   = DATA_W'(s_axis_tdata[36:5]);
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_pos_e = CMP_W'(w_pos);
    assign w_cnt_e = CMP_W'(r_count);

    assign w_ins_ok = w_acc && (w_op == OP_INSERT)
                      && (w_cnt_e < CMP_W'(r_cap))
                      && (w_cnt_e < CMP_W'(DEPTH))
                      && (w_pos_e <= w_cnt_e);
    assign w_rem_ok = w_acc && (w_op == OP_REMOVE)
                      && (w_pos != '0) && (w_pos_e <= w_cnt_e);

    assign w_ctl.acc  = w_acc;
    assign w_ctl.ins  = w_ins_ok;
    assign w_ctl.rem  = w_rem_ok;
    assign w_ctl.srch = w_acc && (w_op == OP_SEARCH);
    assign w_ctl.pos  = w_pos;

    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + 1'b1;
        end else if (w_rem_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        plirs_cell #(
            .DEPTH  (DEPTH),
            .DATA_W (DATA_W),
            .IDX    (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_value    (w_val),
            .i_left     ((g == 0) ? w_val : w_data[(g == 0) ? 0 : g - 1]),
            .i_right    (w_data[(g == DEPTH - 1) ? g : g + 1]),
            .o_data     (w_data[g]),
            .o_sel_data (w_sel[g]),
            .o_hit      (w_hit[g])
        );
    end

    always_comb begin
        w_rdata = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rdata = w_rdata | w_sel[i];
        end
    end

    // first match: isolate lowest set bit, then encode
    assign w_first = w_hit & (~w_hit + 1'b1);
    assign w_any   = |w_hit;

    always_comb begin
        w_idx = '0;
        for (int b = 0; b < IDX_W; b++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (((i >> b) & 1) == 1) begin
                    w_idx[b] = w_idx[b] | w_first[i];
                end
            end
        end
    end

    assign w_found = w_any ? (CNT_W'(w_idx) + 1'b1) : '0;

    assign w_s1_go       = r_s1_valid && (!r_ov || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_go;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RST;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            r_count <= n_count;
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_go) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_ok    <= w_ins_ok || w_rem_ok;
            r_s1_srch  <= w_ctl.srch;
            r_s1_rdata <= w_rdata;
            r_s1_len   <= n_count;
        end
        if (w_s1_go) begin
            r_o_ok    <= r_s1_ok || (r_s1_srch && w_any);
            r_o_rdata <= VAL_W'(r_s1_rdata);
            r_o_found <= r_s1_srch ? LEN_W'(w_found) : '0;
            r_o_len   <= LEN_W'(r_s1_len);
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_ok;
    assign m_axis_tdata  = {6'd0, r_o_len, r_o_found, r_o_rdata};

endmodule
`default_nettype wire

// ----- hdl/plirs_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plirs_chk
// Port-level checks for the positional list block, bound to the top level.
// ----------------------------------------------------------------------------
module plirs_chk
    import plirs_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata,
    input wire [0:0]  m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result word changed under stall");

    // a failed operation reports no removed value and no position
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
        (m_axis_tdata[36:0] == 37'd0))
        else $error("failed operation with nonzero payload");

    // a reported position lies inside the list
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[36:32] != 5'd0) |->
        (m_axis_tuser[0] && m_axis_tdata[36:32] <= m_axis_tdata[41:37]))
        else $error("found position outside list");

    // length never exceeds the row
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[41:37]) <= DEPTH_DEF))
        else $error("length beyond depth");

endmodule

bind positional_list_insert_remove_search plirs_chk u_plirs_chk (.*);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list (insert, remove, search).
// A behavioral list model predicts every result word from the accepted
// command words and the capacity register. A monitor compares the ok flag,
// removed value, found position and length field by field. Directed cases
// cover the list ends, bad positions, the unused opcode and capacity
// extremes. Backpressure holds the output off long enough to stall the input.
// A random mix then runs over several capacity settings, with random idling
// on both streams after the first setting.
// ----------------------------------------------------------------------------
module tb;
    import plirs_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] removed;
        logic [POS_W-1:0] found;
        logic [LEN_W-1:0] len;
    } t_list_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // position[4:0], value[36:5], zero
    logic [1:0]  s_axis_tuser = '0;    // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // removed[31:0], found[36:32], length[41:37]
    logic [0:0]  m_axis_tuser;         // ok[0]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;      // capacity

    // list model
    logic [VAL_W-1:0] list_mem [DEPTH_DEF];
    int               list_len = 0;
    int               cap_model = CAP_RST;
    t_list_res        list_results_q[$];
    t_list_res        exp_r;

    int  err_cnt = 0;
    int  n_words_in = 0;
    int  n_results = 0;
    int  n_ins_ok = 0;
    int  n_rem_ok = 0;
    int  n_srch_hit = 0;
    int  n_not_ok = 0;
    int  n_cap_writes = 0;
    bit  src_idle = 1'b0;
    bit  snk_idle = 1'b0;
    int  snk_hold = 0;

    positional_list_insert_remove_search i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic int usable_cap();
        return (cap_model > DEPTH_DEF) ? DEPTH_DEF : cap_model;
    endfunction

    function automatic t_list_res apply_list_op(input logic [OP_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic [VAL_W-1:0] val);
        t_list_res r;
        r = '0;
        case (op)
            OP_INSERT: begin
                if (list_len < usable_cap() && pos <= list_len) begin
                    for (int k = list_len; k > pos; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pos] = val;
                    list_len++;
                    r.ok = 1'b1;
                    n_ins_ok++;
                end
            end
            OP_REMOVE: begin
                if (pos >= 1 && pos <= list_len) begin
                    r.removed = list_mem[pos-1];
                    for (int k = pos; k < list_len; k++)
                        list_mem[k-1] = list_mem[k];
                    list_len--;
                    r.ok = 1'b1;
                    n_rem_ok++;
                end
            end
            OP_SEARCH: begin
                for (int k = 0; k < list_len; k++) begin
                    if (!r.ok && list_mem[k] == val) begin
                        r.ok    = 1'b1;
                        r.found = POS_W'(k + 1);
                    end
                end
                if (r.ok)
                    n_srch_hit++;
            end
            default: ;
        endcase
        if (!r.ok)
            n_not_ok++;
        r.len = LEN_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        err_cnt++;
        $display("ERROR %0t ns: %s expected %h got %h", $time, what, exp_v, got_v);
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            n_results++;
            if (list_results_q.size() == 0) begin
                report_mismatch("word with none pending", '0, m_axis_tdata[31:0]);
            end else begin
                exp_r = list_results_q.pop_front();
                if (m_axis_tuser[0] !== exp_r.ok)
                    report_mismatch("ok", exp_r.ok, m_axis_tuser[0]);
                if (m_axis_tdata[31:0] !== exp_r.removed)
                    report_mismatch("removed_value", exp_r.removed, m_axis_tdata[31:0]);
                if (m_axis_tdata[36:32] !== exp_r.found)
                    report_mismatch("found_position", exp_r.found, m_axis_tdata[36:32]);
                if (m_axis_tdata[41:37] !== exp_r.len)
                    report_mismatch("length", exp_r.len, m_axis_tdata[41:37]);
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (snk_hold > 0) begin
                m_axis_tready = 1'b0;
                snk_hold--;
            end else begin
                m_axis_tready = !(snk_idle && $urandom_range(0, 99) < 22);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        if (src_idle && $urandom_range(0, 99) < 22) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {3'b000, val, pos};
        s_axis_tuser  = op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        list_results_q.push_back(apply_list_op(op, pos, val));
        n_words_in++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid = 1'b0;
        while (list_results_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drain();
        i_cfg_data  = cap;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cap_model = cap;
        n_cap_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_directed();
        send_cmd(OP_SEARCH, 5'd0, 32'h0000_0000);     // empty search
        send_cmd(OP_REMOVE, 5'd1, 32'h0);             // remove from empty
        send_cmd(OP_INSERT, 5'd1, 32'h1111_1111);     // past length
        send_cmd(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_cmd(OP_INSERT, 5'd1, 32'h0000_0000);     // at tail
        send_cmd(OP_INSERT, 5'd0, 32'h5A5A_5A5A);     // at front
        send_cmd(OP_INSERT, 5'd2, 32'hA5A5_A5A5);     // middle
        send_cmd(OP_SEARCH, 5'd31, 32'h0000_0000);    // last element
        send_cmd(OP_SEARCH, 5'd0, 32'hFFFF_FFFF);
        send_cmd(OP_SEARCH, 5'd0, 32'h1234_5678);     // miss
        send_cmd(OP_INSERT, 5'd1, 32'hFFFF_FFFF);     // duplicate, first match keeps its position
        send_cmd(OP_SEARCH, 5'd0, 32'hFFFF_FFFF);
        send_cmd(OP_NONE, 5'd31, 32'hFFFF_FFFF);      // unused opcode
        send_cmd(OP_REMOVE, 5'd0, 32'hFFFF_FFFF);
        send_cmd(OP_REMOVE, 5'd31, 32'h0);
        send_cmd(OP_REMOVE, 5'd6, 32'h0);             // one past length
        send_cmd(OP_REMOVE, 5'd5, 32'h0);             // last
        send_cmd(OP_REMOVE, 5'd1, 32'h0);             // first
        send_cmd(OP_INSERT, 5'd31, 32'h8000_0000);
        send_cmd(OP_INSERT, 5'd3, 32'h8000_0001);
        wait_drain();
    endtask

    task automatic test_capacity_limits();
        while (list_len < DEPTH_DEF)
            send_cmd(OP_INSERT, POS_W'(list_len), $urandom);
        send_cmd(OP_INSERT, 5'd16, 32'hDEAD_BEEF);    // full at 16
        send_cmd(OP_SEARCH, 5'd0, list_mem[DEPTH_DEF-1]);
        send_cmd(OP_REMOVE, 5'd16, 32'h0);

        write_capacity(5'd4);                         // below length
        send_cmd(OP_INSERT, 5'd0, 32'h0BAD_0BAD);
        send_cmd(OP_SEARCH, 5'd0, list_mem[list_len-1]);
        while (list_len > 3)
            send_cmd(OP_REMOVE, 5'd1, 32'h0);
        send_cmd(OP_INSERT, 5'd3, 32'h0000_0004);
        send_cmd(OP_INSERT, 5'd0, 32'h0000_0005);

        write_capacity(5'd0);
        send_cmd(OP_INSERT, 5'd0, 32'h0000_0006);
        while (list_len > 0)
            send_cmd(OP_REMOVE, POS_W'($urandom_range(1, list_len)), 32'h0);
        send_cmd(OP_INSERT, 5'd0, 32'h0000_0007);

        write_capacity(5'd31);                        // saturates to depth
        while (list_len < DEPTH_DEF)
            send_cmd(OP_INSERT, POS_W'($urandom_range(0, list_len)), $urandom);
        send_cmd(OP_INSERT, 5'd0, 32'h0000_0008);

        write_capacity(5'd1);
        while (list_len > 0)
            send_cmd(OP_REMOVE, POS_W'($urandom_range(1, list_len)), 32'h0);
        send_cmd(OP_INSERT, 5'd0, 32'h0000_0009);
        send_cmd(OP_INSERT, 5'd1, 32'h0000_000A);
        write_capacity(CAP_RST);
    endtask

    task automatic test_backpressure();
        snk_hold = 50;
        for (int i = 0; i < 12; i++) begin
            if (i[0])
                send_cmd(OP_SEARCH, 5'd0, list_mem[0]);
            else
                send_cmd(OP_INSERT, POS_W'(list_len), $urandom);
        end
        wait_drain();
    endtask

    task automatic run_mix(input int n_items);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < ((list_len < usable_cap()) ? 45 : 25))
                op = OP_INSERT;
            else if (pick < 75)
                op = OP_REMOVE;
            else if (pick < 96)
                op = OP_SEARCH;
            else
                op = OP_NONE;

            if ($urandom_range(0, 9) == 0)
                pos = POS_W'($urandom);
            else if (op == OP_INSERT)
                pos = POS_W'($urandom_range(0, list_len));
            else if (list_len > 0)
                pos = POS_W'($urandom_range(1, list_len));
            else
                pos = '0;

            case ($urandom_range(0, 3))
                0: val = $urandom;
                1: val = (list_len > 0) ? list_mem[$urandom_range(0, list_len - 1)]
                                        : $urandom;
                2: val = $urandom_range(0, 3);
                default: val = 32'hFFFF_FFFF - $urandom_range(0, 3);
            endcase
            send_cmd(op, pos, val);
        end
    endtask

    task automatic test_random_mix();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        write_capacity(5'd16);
        run_mix(300);
        src_idle = 1'b1;
        snk_idle = 1'b1;
        write_capacity(5'd31);
        run_mix(250);
        write_capacity(5'd8);
        run_mix(250);
        write_capacity(5'd3);
        run_mix(200);
        write_capacity(5'd0);
        run_mix(150);
        write_capacity(5'd1);
        run_mix(150);
        write_capacity(5'd12);
        run_mix(250);
        write_capacity(5'd17);
        run_mix(250);
        write_capacity(5'd16);
        run_mix(250);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        test_directed();
        test_capacity_limits();
        test_backpressure();
        test_random_mix();
        wait_drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d command words, %0d result words, %0d capacity writes",
                 n_words_in, n_results, n_cap_writes);
        $display("  %0d inserts, %0d removes, %0d search hits, %0d not ok; %0d errors",
                 n_ins_ok, n_rem_ok, n_srch_hit, n_not_ok, err_cnt);
        if (err_cnt == 0 && list_results_q.size() == 0) begin
            $display("PASS positional_list_insert_remove_search");
        end else begin
            $display("FAIL positional_list_insert_remove_search");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d result words pending", list_results_q.size());
        $display("FAIL positional_list_insert_remove_search");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/plirs_pkg.sv
hdl/plirs_cell.sv
hdl/positional_list_insert_remove_search.sv
hdl/plirs_chk.sv
tb/sv/tb.sv
